>>> src/timer_slot_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Timer slot scheduler assertion macros
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_SCHEDULER_ASSERT_SVH
`define TIMER_SLOT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Constants and types for the timer slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

   localparam int DEF_TIMER_SLOTS = 16;
   localparam int DEF_TIME_BITS   = 48;
   localparam int MAX_FIRE        = 16;
   localparam int SLOT_PORT_W     = 4;
   localparam int IVL_W           = 24;
   localparam int AMT_W           = 16;
   localparam int FCNT_W          = $clog2(MAX_FIRE + 1);

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

endpackage

`default_nettype wire

>>> src/tss_ram.sv
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/timer_slot_scheduler.sv
// ----------------------------------------------------------------------------
// timer_slot_scheduler
// Multi-slot timer queue: arm, disarm and tick with time-ordered expiry.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. kind selects
//   tick, start slot or stop slot. Start and stop complete in the accepting
//   cycle and never raise busy.
//   A tick raises busy and runs one scan pass over the slot RAM per expiry,
//   or a single pass if nothing is due. A pass reads one slot per cycle
//   through the RAM read port; a tick that fires k slots runs max(k,1)
//   passes (k is at most 16).
//   Each expiry appears on the rsp_ ports for one cycle with rsp_strobe,
//   earliest fire time first, ties to the lowest slot; rsp_last marks the
//   final beat of the tick. A tick that fires nothing gives no beat.
//   The receiver cannot stall: beats are never held.
//   Reset clears the time base and all running flags; slot RAM contents
//   are don't-care until a start writes them, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_slot_scheduler_assert.svh"

module timer_slot_scheduler #(
   parameter int TIMER_SLOTS = tss_pkg::DEF_TIMER_SLOTS,
   parameter int TIME_BITS   = tss_pkg::DEF_TIME_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_kind,
   input  wire logic [tss_pkg::SLOT_PORT_W-1:0] req_slot,
   input  wire logic [tss_pkg::IVL_W-1:0]       req_interval,
   input  wire logic [tss_pkg::IVL_W-1:0]       req_reload_interval,
   input  wire logic [tss_pkg::AMT_W-1:0]       req_tick_amount,
   output logic                                 rsp_strobe,
   output logic [tss_pkg::SLOT_PORT_W-1:0]      rsp_fired_slot,
   output logic [tss_pkg::IVL_W-1:0]            rsp_fired_interval,
   output logic                                 rsp_last
);

   localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
   localparam int IVL_W   = tss_pkg::IVL_W;
   localparam int ENTRY_W = TIME_BITS + 2 * IVL_W;
   localparam int FCNT_W  = tss_pkg::FCNT_W;
   localparam int SUM_W   = ((TIME_BITS > IVL_W) ? TIME_BITS : IVL_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIRE
   } state_type;

   // clamps at the largest time value, also when the delta is wider than time
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [IVL_W-1:0]     b);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) + SUM_W'(b);
      return (sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

   state_type              state_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [TIMER_SLOTS-1:0] running_ff;
   logic [TIMER_SLOTS-1:0] done_ff;
   logic [CNT_W-1:0]       issue_ff;
   logic                   rd_vld_ff;
   logic [SLOT_W-1:0]      rd_idx_ff;
   logic [CNT_W-1:0]       cand_cnt_ff;
   logic [SLOT_W-1:0]      best_slot_ff;
   logic [TIME_BITS-1:0]   best_time_ff;
   logic [IVL_W-1:0]       best_cur_ff;
   logic [IVL_W-1:0]       best_rel_ff;
   logic [FCNT_W-1:0]      fire_cnt_ff;
   logic                   rsp_strobe_ff;
   logic [tss_pkg::SLOT_PORT_W-1:0] rsp_slot_ff;
   logic [IVL_W-1:0]       rsp_ivl_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   slot_ok;
   logic                   start_wr;
   logic                   rearm_wr;
   logic                   mem_we;
   logic [SLOT_W-1:0]      mem_waddr;
   logic [ENTRY_W-1:0]     mem_wdata;
   logic [ENTRY_W-1:0]     mem_rdata;
   logic [TIME_BITS-1:0]   rd_time;
   logic [IVL_W-1:0]       rd_cur;
   logic [IVL_W-1:0]       rd_rel;
   logic                   cand;
   logic                   better;
   logic                   scan_end;
   logic                   fire_last;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign slot_ok  = int'(req_slot) < TIMER_SLOTS;
   assign start_wr = accept && (req_kind == tss_pkg::KIND_START) && slot_ok &&
                     (req_interval != '0);
   assign rearm_wr = (state_ff == ST_FIRE) && (cand_cnt_ff != '0) && (best_rel_ff != '0);
   assign mem_we   = start_wr || rearm_wr;

   always_comb begin
      if (start_wr) begin
         mem_waddr = SLOT_W'(req_slot);
         mem_wdata = {sat_add(now_ff, req_interval), req_interval, req_reload_interval};
      end else begin
         mem_waddr = best_slot_ff;
         mem_wdata = {sat_add(now_ff, best_rel_ff), best_rel_ff, best_rel_ff};
      end
   end

   tss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TIMER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (issue_ff[SLOT_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign {rd_time, rd_cur, rd_rel} = mem_rdata;

   assign cand      = rd_vld_ff && running_ff[rd_idx_ff] && !done_ff[rd_idx_ff] &&
                      (rd_time <= now_ff);
   assign better    = cand && ((cand_cnt_ff == '0) || (rd_time < best_time_ff));
   assign scan_end  = rd_vld_ff && (rd_idx_ff == SLOT_W'(TIMER_SLOTS - 1));
   // final beat: only one due slot left, or the per-tick cap is reached
   assign fire_last = (cand_cnt_ff == CNT_W'(1)) ||
                      (fire_cnt_ff == FCNT_W'(tss_pkg::MAX_FIRE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         running_ff    <= '0;
         done_ff       <= '0;
         issue_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         cand_cnt_ff   <= '0;
         fire_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_FIRE) && (cand_cnt_ff != '0);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_kind)
                     tss_pkg::KIND_TICK: begin
                        now_ff      <= sat_add(now_ff, IVL_W'(req_tick_amount));
                        done_ff     <= '0;
                        fire_cnt_ff <= '0;
                        issue_ff    <= '0;
                        cand_cnt_ff <= '0;
                        state_ff    <= ST_SCAN;
                     end
                     tss_pkg::KIND_START: begin
                        if (start_wr) begin
                           running_ff[SLOT_W'(req_slot)] <= 1'b1;
                        end
                     end
                     tss_pkg::KIND_STOP: begin
                        if (slot_ok) begin
                           running_ff[SLOT_W'(req_slot)] <= 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (issue_ff != CNT_W'(TIMER_SLOTS)) begin
                  issue_ff  <= issue_ff + CNT_W'(1);
                  rd_vld_ff <= 1'b1;
                  rd_idx_ff <= issue_ff[SLOT_W-1:0];
               end else begin
                  rd_vld_ff <= 1'b0;
               end
               if (cand) begin
                  cand_cnt_ff <= cand_cnt_ff + CNT_W'(1);
               end
               if (better) begin
                  best_slot_ff <= rd_idx_ff;
                  best_time_ff <= rd_time;
                  best_cur_ff  <= rd_cur;
                  best_rel_ff  <= rd_rel;
               end
               if (scan_end) begin
                  state_ff <= ST_FIRE;
               end
            end
            ST_FIRE: begin
               if (cand_cnt_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  rsp_slot_ff           <= tss_pkg::SLOT_PORT_W'(best_slot_ff);
                  rsp_ivl_ff            <= best_cur_ff;
                  rsp_last_ff           <= fire_last;
                  done_ff[best_slot_ff] <= 1'b1;
                  fire_cnt_ff           <= fire_cnt_ff + FCNT_W'(1);
                  // one-shot slots stop; reloading slots were rewritten in RAM
                  if (best_rel_ff == '0) begin
                     running_ff[best_slot_ff] <= 1'b0;
                  end
                  if (fire_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     issue_ff    <= '0;
                     cand_cnt_ff <= '0;
                     state_ff    <= ST_SCAN;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_fired_slot     = rsp_slot_ff;
   assign rsp_fired_interval = rsp_ivl_ff;
   assign rsp_last           = rsp_last_ff;

   `TSS_ASSERT_NOW(a_last_ends_tick, clock, reset, rsp_strobe && rsp_last, !busy,
      "final beat of a tick while still busy")
   `TSS_ASSERT_NOW(a_more_keeps_busy, clock, reset, rsp_strobe && !rsp_last, busy,
      "non-final beat but tick already finished")
   `TSS_ASSERT_NEXT(a_beats_spaced, clock, reset, rsp_strobe, !rsp_strobe,
      "two expiry beats in consecutive cycles")
   `TSS_ASSERT_NEXT(a_tick_busy, clock, reset,
      start && !busy && (req_kind == tss_pkg::KIND_TICK), busy,
      "accepted tick did not start a scan")
   `TSS_ASSERT_NOW(a_fire_cap, clock, reset, busy,
      fire_cnt_ff < FCNT_W'(tss_pkg::MAX_FIRE),
      "expiry count reached the cap while a tick is still running")

endmodule

`default_nettype wire

>>> tb/sv/tss_firing_checker.sv
// ----------------------------------------------------------------------------
// tss_firing_checker
// Watches the command and expiry ports of the timer slot scheduler, keeps a
// shadow of the slot table and time base, and compares every expiry beat
// against the predicted order. Reports a running mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tss_firing_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [1:0]                      req_kind,
   input  wire logic [tss_pkg::SLOT_PORT_W-1:0] req_slot,
   input  wire logic [tss_pkg::IVL_W-1:0]       req_interval,
   input  wire logic [tss_pkg::IVL_W-1:0]       req_reload_interval,
   input  wire logic [tss_pkg::AMT_W-1:0]       req_tick_amount,
   input  wire logic                            rsp_strobe,
   input  wire logic [tss_pkg::SLOT_PORT_W-1:0] rsp_fired_slot,
   input  wire logic [tss_pkg::IVL_W-1:0]       rsp_fired_interval,
   input  wire logic                            rsp_last,
   output int                                   fail_count,
   output int                                   pending
);
   import tss_pkg::*;

   localparam int SLOTS = DEF_TIMER_SLOTS;
   localparam int TBITS = DEF_TIME_BITS;

   typedef logic [TBITS-1:0] stamp_type;
   typedef logic [IVL_W-1:0] ivl_type;

   typedef struct packed {
      logic [SLOT_PORT_W-1:0] slot;
      ivl_type                interval;
      logic                   last;
   } beat_type;

   beat_type expected_firings[$];

   // shadow of the scheduler state
   stamp_type  now_units;
   stamp_type  due_at    [SLOTS];
   ivl_type    period_now[SLOTS];
   ivl_type    reload_of [SLOTS];
   logic       armed     [SLOTS];

   function automatic stamp_type add_saturating(stamp_type base, ivl_type delta);
      logic [TBITS:0] sum;
      sum = {1'b0, base} + delta;
      return sum[TBITS] ? {TBITS{1'b1}} : sum[TBITS-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic predict_command(logic [1:0] kind, logic [SLOT_PORT_W-1:0] slot,
                                  ivl_type ivl, ivl_type rel,
                                  logic [AMT_W-1:0] amt);
      logic       fired[SLOTS];
      int         best;
      int         count;
      logic       done;
      logic       have_held;
      beat_type   held;
      case (kind)
         KIND_START: begin
            if (slot < SLOTS && ivl != 0) begin
               due_at[slot]     = add_saturating(now_units, ivl);
               period_now[slot] = ivl;
               reload_of[slot]  = rel;
               armed[slot]      = 1'b1;
            end
         end
         KIND_STOP: begin
            if (slot < SLOTS)
               armed[slot] = 1'b0;
         end
         KIND_TICK: begin
            now_units = add_saturating(now_units, ivl_type'(amt));
            foreach (fired[i]) fired[i] = 1'b0;
            count     = 0;
            done      = 1'b0;
            have_held = 1'b0;
            while (count < MAX_FIRE && !done) begin
               best = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (armed[i] && !fired[i] && due_at[i] <= now_units)
                     if (best < 0 || due_at[i] < due_at[best])
                        best = i;
               end
               if (best < 0) begin
                  done = 1'b1;
               end else begin
                  if (have_held)
                     expected_firings.push_back(held);
                  fired[best]   = 1'b1;
                  held.slot     = best[SLOT_PORT_W-1:0];
                  held.interval = period_now[best];
                  held.last     = 1'b0;
                  have_held     = 1'b1;
                  count++;
                  if (reload_of[best] != 0) begin
                     period_now[best] = reload_of[best];
                     due_at[best]     = add_saturating(now_units, reload_of[best]);
                  end else begin
                     armed[best] = 1'b0;
                  end
               end
            end
            // final beat of the tick carries last
            if (have_held) begin
               held.last = 1'b1;
               expected_firings.push_back(held);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_firing();
      beat_type want;
      if (expected_firings.size() == 0) begin
         report_mismatch($sformatf("unexpected beat slot %0d interval %0d last %0d",
                                   rsp_fired_slot, rsp_fired_interval, rsp_last));
      end else begin
         want = expected_firings.pop_front();
         if (rsp_fired_slot !== want.slot)
            report_mismatch($sformatf("fired_slot expected %0d got %0d",
                                      want.slot, rsp_fired_slot));
         if (rsp_fired_interval !== want.interval)
            report_mismatch($sformatf("fired_interval expected %0d got %0d (slot %0d)",
                                      want.interval, rsp_fired_interval, want.slot));
         if (rsp_last !== want.last)
            report_mismatch($sformatf("last expected %0d got %0d (slot %0d)",
                                      want.last, rsp_last, want.slot));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         now_units = '0;
         foreach (armed[i]) armed[i] = 1'b0;
         expected_firings.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe)
            check_firing();
         if (start && !busy)
            predict_command(req_kind, req_slot, req_interval, req_reload_interval,
                            req_tick_amount);
      end
      pending <= expected_firings.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives start, stop, tick and ignored commands into the timer slot
// scheduler: a directed opening, then random arm/disarm/tick traffic with
// idle bursts. The checker instance predicts and compares every expiry beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import tss_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_BEATS = 305;
   localparam int         QUIET_TAIL   = 60;
   localparam int         SETTLE_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic [1:0]             req_kind;
   logic [SLOT_PORT_W-1:0] req_slot;
   logic [IVL_W-1:0]       req_interval;
   logic [IVL_W-1:0]       req_reload_interval;
   logic [AMT_W-1:0]       req_tick_amount;
   logic                   busy;
   logic                   rsp_strobe;
   logic [SLOT_PORT_W-1:0] rsp_fired_slot;
   logic [IVL_W-1:0]       rsp_fired_interval;
   logic                   rsp_last;
   int                     fail_count;
   int                     pending;

   timer_slot_scheduler DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_slot            (req_slot),
      .req_interval        (req_interval),
      .req_reload_interval (req_reload_interval),
      .req_tick_amount     (req_tick_amount),
      .rsp_strobe          (rsp_strobe),
      .rsp_fired_slot      (rsp_fired_slot),
      .rsp_fired_interval  (rsp_fired_interval),
      .rsp_last            (rsp_last)
   );

   tss_firing_checker firing_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_slot            (req_slot),
      .req_interval        (req_interval),
      .req_reload_interval (req_reload_interval),
      .req_tick_amount     (req_tick_amount),
      .rsp_strobe          (rsp_strobe),
      .rsp_fired_slot      (rsp_fired_slot),
      .rsp_fired_interval  (rsp_fired_interval),
      .rsp_last            (rsp_last),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   // one command beat; returns at the edge that takes it
   task automatic issue_command(logic [1:0] kind, logic [SLOT_PORT_W-1:0] slot,
                                logic [IVL_W-1:0] ivl, logic [IVL_W-1:0] rel,
                                logic [AMT_W-1:0] amt);
      req_kind            <= kind;
      req_slot            <= slot;
      req_interval        <= ivl;
      req_reload_interval <= rel;
      req_tick_amount     <= amt;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // mostly short intervals and small ticks so slots actually expire
   task automatic random_command();
      int               pick;
      int               roll;
      logic [1:0]       kind;
      logic [IVL_W-1:0] ivl;
      logic [IVL_W-1:0] rel;
      logic [AMT_W-1:0] amt;
      pick = $urandom_range(0, 99);
      if (pick < 45)      kind = KIND_START;
      else if (pick < 62) kind = KIND_STOP;
      else if (pick < 95) kind = KIND_TICK;
      else                kind = KIND_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 4)       ivl = '0;
      else if (roll < 86) ivl = IVL_W'($urandom_range(1, 300));
      else                ivl = IVL_W'($urandom_range(1, 24'hFFFFFF));
      roll = $urandom_range(0, 99);
      if (roll < 45)      rel = '0;
      else if (roll < 88) rel = IVL_W'($urandom_range(1, 300));
      else                rel = IVL_W'($urandom_range(0, 24'hFFFFFF));
      roll = $urandom_range(0, 99);
      if (roll < 85)      amt = AMT_W'($urandom_range(0, 150));
      else                amt = AMT_W'($urandom_range(0, 16'hFFFF));
      issue_command(kind, SLOT_PORT_W'($urandom_range(0, 15)), ivl, rel, amt);
   endtask

   initial begin
      reset               <= 1'b1;
      start               <= 1'b0;
      req_kind            <= KIND_TICK;
      req_slot            <= '0;
      req_interval        <= '0;
      req_reload_interval <= '0;
      req_tick_amount     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      issue_command(KIND_TICK, 0, 0, 0, 0);
      issue_command(KIND_START, 0, 1, 0, 0);
      issue_command(KIND_TICK, 0, 0, 0, 1);
      issue_command(KIND_START, 15, 24'hFFFFFF, 24'hFFFFFF, 0);
      issue_command(KIND_STOP, 15, 0, 0, 0);
      issue_command(KIND_START, 3, 0, 24'hFFFFFF, 0);       // zero interval
      issue_command(KIND_UNUSED, 4'hF, '1, '1, '1);
      // all slots due at once: order by fire time, ties to the low slot;
      // slots 1 and 7 reload by one unit and must fire once per tick
      for (int i = 0; i < DEF_TIMER_SLOTS; i++)
         issue_command(KIND_START, SLOT_PORT_W'(i), IVL_W'(3 - (i % 3)),
                       IVL_W'((i == 1 || i == 7) ? 1 : 0), '0);
      issue_command(KIND_TICK, 0, 0, 0, 16'hFFFF);
      issue_command(KIND_TICK, 0, 0, 0, 1);
      wait_drained();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 2)
            wait_drained();
         if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 4));
         random_command();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
